// File: design/falc_pkg.sv
package falc_pkg;

  // Defaults for the top-level parameters
  localparam int ADDR_WIDTH_DEF  = 32;
  localparam int LINE_BYTES_DEF  = 32;
  localparam int CACHE_BYTES_DEF = 16384;
  localparam int AGE_WIDTH_DEF   = 32;

  // Fixed field widths of the two channels
  localparam int ADDR_BITS  = 32;
  localparam int USED_BITS  = 9;
  localparam int COUNT_BITS = 32;

  typedef struct packed {
    logic [ADDR_BITS-1:0] address;
  } falc_req_t;

  typedef struct packed {
    logic                  hit;
    logic [USED_BITS-1:0]  entry_used;
    logic [COUNT_BITS-1:0] hit_total;
    logic [COUNT_BITS-1:0] access_total;
  } falc_rsp_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_SCAN_LAST,
    S_UPD,
    S_UPD_LAST,
    S_PUSH
  } falc_state_t;

  typedef struct packed {
    logic start;
    logic step;
  } falc_scan_ctl_t;

  // floor(log2(v)), elaboration only
  function automatic int flog2(input int v);
    int n;
    int x;
    n = 0;
    x = v;
    while (x > 1) begin
      x = x >> 1;
      n++;
    end
    return n;
  endfunction

endpackage

// File: design/falc_stream_if.sv
interface falc_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: design/falc_ram.sv
module falc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: design/falc_scan.sv
module falc_scan
  import falc_pkg::*;
#(
  parameter int TAG_W = 27,
  parameter int AGE_W = 32,
  parameter int IDX_W = 9
) (
  input  logic           clk,
  input  logic           rst,
  input  falc_scan_ctl_t ctl,
  input  logic [IDX_W-1:0] idx,
  input  logic           ent_valid,
  input  logic [TAG_W-1:0] ent_tag,
  input  logic [AGE_W-1:0] ent_age,
  input  logic [TAG_W-1:0] key,
  output logic           hit,
  output logic [IDX_W-1:0] hit_idx,
  output logic [IDX_W-1:0] vic_idx
);
  logic [AGE_W-1:0] vic_age;
  logic             match;

  assign match = ent_valid && (ent_tag == key);

  always_ff @(posedge clk) begin
    if (rst || ctl.start) begin
      hit <= 1'b0;
    end else if (ctl.step && !hit && match) begin
      hit <= 1'b1;
    end
  end

  // first match wins; oldest age wins with strict compare so low index takes ties
  always_ff @(posedge clk) begin
    if (ctl.step) begin
      if (!hit && match) begin
        hit_idx <= idx;
      end
      if (idx == '0 || ent_age > vic_age) begin
        vic_idx <= idx;
        vic_age <= ent_age;
      end
    end
  end
endmodule

// File: design/full_assoc_lru_cache_lookup.sv
// An accepted input beat passes through S_SCAN, S_SCAN_LAST, S_UPD, S_UPD_LAST
// and S_PUSH (N = CACHE_BYTES / LINE_BYTES entries); the output beat is registered.
// Input is not ready again until the result is pushed (a stalled output holds S_PUSH),
// as the single read port of the tag/age memories is shared: one pass reads every
// entry to match and pick the victim, a second pass rewrites every age.
// Reset: synchronous; a clearing pass over all N entries follows, input not ready.
module full_assoc_lru_cache_lookup
  import falc_pkg::*;
#(
  parameter int ADDR_WIDTH  = ADDR_WIDTH_DEF,
  parameter int LINE_BYTES  = LINE_BYTES_DEF,
  parameter int CACHE_BYTES = CACHE_BYTES_DEF,
  parameter int AGE_WIDTH   = AGE_WIDTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  falc_stream_if.sink   req,
  falc_stream_if.source rsp
);
  localparam int OFF     = flog2(LINE_BYTES);
  localparam int ENTRIES = ((CACHE_BYTES / LINE_BYTES) > 0) ? (CACHE_BYTES / LINE_BYTES) : 1;
  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int TAG_W   = (ADDR_WIDTH > OFF) ? (ADDR_WIDTH - OFF) : 1;
  localparam int EXT_W   = (ADDR_WIDTH > ADDR_BITS) ? ADDR_WIDTH : ADDR_BITS;
  localparam logic [EXT_W-1:0] AW_MASK =
    (ADDR_WIDTH >= EXT_W) ? {EXT_W{1'b1}} : ((EXT_W'(1) << ADDR_WIDTH) - EXT_W'(1));
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

  falc_state_t state, state_next;

  logic [IDX_W-1:0] idx, idx_next;
  logic             pv;
  logic [IDX_W-1:0] pidx;
  logic [TAG_W-1:0] key;
  logic [TAG_W-1:0] tag_in;
  logic             accept;
  logic             issue;

  logic [COUNT_BITS-1:0] hit_counter;
  logic [COUNT_BITS-1:0] access_counter;
  logic                  out_valid;
  falc_rsp_t             out_data;

  // memories: {valid, tag} and age
  logic             tag_we;
  logic [IDX_W-1:0] tag_waddr;
  logic [TAG_W:0]   tag_wdata;
  logic [TAG_W:0]   tag_rd;
  logic             age_we;
  logic [IDX_W-1:0] age_waddr;
  logic [AGE_WIDTH-1:0] age_wdata;
  logic [AGE_WIDTH-1:0] age_rd;

  falc_scan_ctl_t   scan_ctl;
  logic             scan_hit;
  logic [IDX_W-1:0] hit_idx;
  logic [IDX_W-1:0] vic_idx;
  logic [IDX_W-1:0] used_idx;

  logic [EXT_W-1:0] addr_m;

  assign addr_m = EXT_W'(req.data.address) & AW_MASK;
  assign tag_in = TAG_W'(addr_m >> OFF);
  assign accept = req.valid && req.ready;
  assign req.ready = (state == S_IDLE);
  assign rsp.valid = out_valid;
  assign rsp.data  = out_data;

  assign used_idx = scan_hit ? hit_idx : vic_idx;

  assign scan_ctl.start = accept;
  assign scan_ctl.step  = pv && (state == S_SCAN || state == S_SCAN_LAST);

  falc_ram #(.WIDTH(TAG_W + 1), .DEPTH(ENTRIES)) u_tag_ram (
    .clk   (clk),
    .we    (tag_we),
    .waddr (tag_waddr),
    .wdata (tag_wdata),
    .raddr (idx),
    .rdata (tag_rd)
  );

  falc_ram #(.WIDTH(AGE_WIDTH), .DEPTH(ENTRIES)) u_age_ram (
    .clk   (clk),
    .we    (age_we),
    .waddr (age_waddr),
    .wdata (age_wdata),
    .raddr (idx),
    .rdata (age_rd)
  );

  falc_scan #(.TAG_W(TAG_W), .AGE_W(AGE_WIDTH), .IDX_W(IDX_W)) u_scan (
    .clk       (clk),
    .rst       (rst),
    .ctl       (scan_ctl),
    .idx       (pidx),
    .ent_valid (tag_rd[TAG_W]),
    .ent_tag   (tag_rd[TAG_W-1:0]),
    .ent_age   (age_rd),
    .key       (key),
    .hit       (scan_hit),
    .hit_idx   (hit_idx),
    .vic_idx   (vic_idx)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    idx_next   = idx;
    issue      = 1'b0;
    tag_we     = 1'b0;
    tag_waddr  = idx;
    tag_wdata  = '0;
    age_we     = 1'b0;
    age_waddr  = idx;
    age_wdata  = '0;
    unique case (state)
      S_CLEAR: begin
        tag_we = 1'b1;
        age_we = 1'b1;
        if (idx == LAST_IDX) begin
          idx_next   = '0;
          state_next = S_IDLE;
        end else begin
          idx_next = idx + IDX_W'(1);
        end
      end
      S_IDLE: begin
        idx_next = '0;
        if (accept) begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        issue = 1'b1;
        if (idx == LAST_IDX) begin
          state_next = S_SCAN_LAST;
        end else begin
          idx_next = idx + IDX_W'(1);
        end
      end
      S_SCAN_LAST: begin
        idx_next   = '0;
        state_next = S_UPD;
      end
      S_UPD, S_UPD_LAST: begin
        if (state == S_UPD) begin
          issue = 1'b1;
          if (idx == LAST_IDX) begin
            state_next = S_UPD_LAST;
          end else begin
            idx_next = idx + IDX_W'(1);
          end
          // victim takes the new tag once, at the start of the pass
          if (!pv && !scan_hit) begin
            tag_we    = 1'b1;
            tag_waddr = used_idx;
            tag_wdata = {1'b1, key};
          end
        end else begin
          state_next = S_PUSH;
        end
        age_we    = pv;
        age_waddr = pidx;
        if (pidx == used_idx) begin
          age_wdata = '0;
        end else if (&age_rd) begin
          age_wdata = age_rd;
        end else begin
          age_wdata = age_rd + AGE_WIDTH'(1);
        end
      end
      S_PUSH: begin
        if (!out_valid || rsp.ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx            <= '0;
      pv             <= 1'b0;
      hit_counter    <= '0;
      access_counter <= '0;
      out_valid      <= 1'b0;
    end else begin
      idx <= idx_next;
      pv  <= issue;
      if (state == S_UPD_LAST) begin
        hit_counter    <= hit_counter + COUNT_BITS'(scan_hit);
        access_counter <= access_counter + COUNT_BITS'(1);
      end
      if (state == S_PUSH && (!out_valid || rsp.ready)) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    pidx <= idx;
    if (accept) begin
      key <= tag_in;
    end
    if (state == S_PUSH && (!out_valid || rsp.ready)) begin
      out_data.hit          <= scan_hit;
      out_data.entry_used   <= USED_BITS'(used_idx);
      out_data.hit_total    <= hit_counter;
      out_data.access_total <= access_counter;
    end
  end
endmodule

// File: design/falc_checker.sv
module falc_checker
  import falc_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  req_valid,
  input logic                  req_ready,
  input logic                  rsp_valid,
  input logic                  rsp_ready,
  input logic                  rsp_hit,
  input logic [COUNT_BITS-1:0] rsp_hit_total,
  input logic [COUNT_BITS-1:0] rsp_access_total
);
  logic                  seen;
  logic [COUNT_BITS-1:0] last_hits;
  logic [COUNT_BITS-1:0] last_acc;
  logic                  rsp_beat;

  assign rsp_beat = rsp_valid && rsp_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      seen      <= 1'b0;
      last_hits <= '0;
      last_acc  <= '0;
    end else if (rsp_beat) begin
      seen      <= 1'b1;
      last_hits <= rsp_hit_total;
      last_acc  <= rsp_access_total;
    end
  end

  // clearing pass keeps the input closed right after reset
  a_clear_after_reset: assert property (@(posedge clk) rst |=> !req_ready)
    else $error("input ready during clearing pass");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("input ready while an item is in work");

  a_counts_step: assert property (@(posedge clk) disable iff (rst)
    rsp_beat && seen |->
      rsp_access_total == last_acc + COUNT_BITS'(1) &&
      rsp_hit_total == last_hits + COUNT_BITS'(rsp_hit))
    else $error("running counts out of step between beats");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_access_total))
    else $error("stalled result beat dropped or changed");
endmodule

bind full_assoc_lru_cache_lookup falc_checker u_falc_checker (
  .clk              (clk),
  .rst              (rst),
  .req_valid        (req.valid),
  .req_ready        (req.ready),
  .rsp_valid        (rsp.valid),
  .rsp_ready        (rsp.ready),
  .rsp_hit          (rsp.data.hit),
  .rsp_hit_total    (rsp.data.hit_total),
  .rsp_access_total (rsp.data.access_total)
);

// File: dv/tb_full_assoc_lru_cache_lookup.sv
`timescale 1ns / 100ps

module tb_full_assoc_lru_cache_lookup;
  import falc_pkg::*;

  localparam int NUM_LINES   = CACHE_BYTES_DEF / LINE_BYTES_DEF;
  localparam int OFFSET_W    = $clog2(LINE_BYTES_DEF);
  localparam int TAG_W       = ADDR_BITS - OFFSET_W;
  localparam int LOOKUP_LAT  = 2 * NUM_LINES + 8;
  // 585 beats of full-table lookups plus gaps, stalls and the clearing pass
  localparam int CYCLE_LIMIT = 4000000;

  logic clk;
  logic rst;

  falc_stream_if #(.payload_t(falc_req_t)) req_ch ();
  falc_stream_if #(.payload_t(falc_rsp_t)) rsp_ch ();

  full_assoc_lru_cache_lookup dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  // shadow copy of the cache contents
  logic [TAG_W-1:0]         line_tag[NUM_LINES];
  bit                       line_valid[NUM_LINES];
  logic [AGE_WIDTH_DEF-1:0] line_age[NUM_LINES];
  logic [COUNT_BITS-1:0]    hits_seen;
  logic [COUNT_BITS-1:0]    accesses_seen;

  falc_rsp_t              expected_rsp[$];
  logic [ADDR_BITS-1:0]   addr_history[$];
  falc_rsp_t              want;
  falc_rsp_t              got;
  int                     mismatches;
  int                     burst_left;
  int unsigned            cycle_count;
  int unsigned            drain_tick;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic falc_rsp_t cache_lookup(input logic [ADDR_BITS-1:0] address);
    logic [TAG_W-1:0] tag;
    int               slot;
    bit               found;
    falc_rsp_t        r;
    tag   = address[ADDR_BITS-1:OFFSET_W];
    found = 1'b0;
    slot  = 0;
    for (int i = 0; i < NUM_LINES; i++) begin
      if (!found && line_valid[i] && line_tag[i] == tag) begin
        found = 1'b1;
        slot  = i;
      end
    end
    if (!found) begin
      // oldest line goes; strict compare keeps the lowest index on a tie
      for (int i = 1; i < NUM_LINES; i++) begin
        if (line_age[i] > line_age[slot]) slot = i;
      end
      line_tag[slot]   = tag;
      line_valid[slot] = 1'b1;
    end
    for (int i = 0; i < NUM_LINES; i++) begin
      if (i == slot) line_age[i] = '0;
      else if (line_age[i] != '1) line_age[i] = line_age[i] + 1'b1;
    end
    if (found) hits_seen = hits_seen + 1'b1;
    accesses_seen    = accesses_seen + 1'b1;
    r.hit            = found;
    r.entry_used     = slot[USED_BITS-1:0];
    r.hit_total      = hits_seen;
    r.access_total   = accesses_seen;
    return r;
  endfunction

  // result check first, then the prediction for a beat taken at this edge
  always @(posedge clk) begin
    if (!rst) begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        got = rsp_ch.data;
        if (expected_rsp.size() == 0) begin
          $error("result beat with no lookup pending: entry_used %0d", got.entry_used);
          mismatches++;
        end else begin
          want = expected_rsp.pop_front();
          if (got.hit !== want.hit) begin
            $error("hit: expected %0d, actual %0d", want.hit, got.hit);
            mismatches++;
          end
          if (got.entry_used !== want.entry_used) begin
            $error("entry_used: expected %0d, actual %0d", want.entry_used, got.entry_used);
            mismatches++;
          end
          if (got.hit_total !== want.hit_total) begin
            $error("hit_total: expected %0d, actual %0d", want.hit_total, got.hit_total);
            mismatches++;
          end
          if (got.access_total !== want.access_total) begin
            $error("access_total: expected %0d, actual %0d",
                   want.access_total, got.access_total);
            mismatches++;
          end
        end
      end
      if (req_ch.valid && req_ch.ready) begin
        expected_rsp.push_back(cache_lookup(req_ch.data.address));
      end
    end
  end

  // receiver: stall mode rotates through four modes picked by bits 9:8 of drain_tick
  initial begin
    rsp_ch.ready = 1'b0;
    drain_tick   = 0;
    forever begin
      @(negedge clk);
      drain_tick++;
      case (drain_tick[9:8])
        2'd0: rsp_ch.ready <= 1'b1;
        2'd1: rsp_ch.ready <= 1'($urandom_range(0, 1));
        2'd2: rsp_ch.ready <= (drain_tick[2:0] == 3'd0);
        default: rsp_ch.ready <= ~drain_tick[4];
      endcase
    end
  end

  // one address beat; bursts of random length, random idle gaps between them
  task automatic send_address(input logic [ADDR_BITS-1:0] address);
    int gap;
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) == 0) begin
        burst_left = $urandom_range(20, 60);
        gap        = 0;
      end else begin
        burst_left = $urandom_range(1, 6);
        // long gaps land anywhere in the lookup of the previous beat
        gap = ($urandom_range(0, 5) == 0) ? $urandom_range(100, 1100) : $urandom_range(1, 12);
      end
      repeat (gap) begin
        @(negedge clk);
        req_ch.valid <= 1'b0;
        req_ch.data  <= $urandom;
      end
    end
    burst_left--;
    @(negedge clk);
    req_ch.valid        <= 1'b1;
    req_ch.data.address <= address;
    do @(posedge clk); while (!req_ch.ready);
    addr_history.push_back(address);
  endtask

  // same line as an earlier beat, fresh offset bits
  function automatic logic [ADDR_BITS-1:0] reuse_line(input int lo, input int hi);
    logic [ADDR_BITS-1:0] base;
    base = addr_history[$urandom_range(lo, hi)];
    return {base[ADDR_BITS-1:OFFSET_W], OFFSET_W'($urandom)};
  endfunction

  // cold cache: first miss takes line 0, later misses fill in index order
  task automatic test_cold_fill();
    send_address(32'h0000_0000);
    send_address(32'h0000_001F);
    send_address(32'hFFFF_FFFF);
    send_address(32'hFFFF_FFE0);
    send_address(32'h0000_0020);
    send_address(32'h8000_0000);
    send_address(32'h7FFF_FFFF);
  endtask

  task automatic test_tag_patterns();
    send_address(32'hAAAA_AAAA);
    send_address(32'h5555_5555);
    send_address(32'hAAAA_AAB5);
    send_address(32'h5555_554A);
    send_address(32'h1234_5678);
    send_address(32'h1234_5678);
  endtask

  // hits in scrambled order reset ages; a miss after must still pick a fresh line
  task automatic test_hit_refresh();
    send_address(32'h8000_0010);
    send_address(32'h0000_0005);
    send_address(32'hFFFF_FFF0);
    send_address(32'h7FFF_FFE0);
    send_address(32'h0000_0030);
    send_address(32'hDEAD_BEEF);
    send_address(32'h0000_003F);
  endtask

  // mostly new lines, though fewer than the 512 entries, so some stay free
  task automatic test_random_fill();
    for (int n = 0; n < 490; n++) begin
      if ($urandom_range(0, 49) == 0) send_address(reuse_line(0, addr_history.size() - 1));
      else send_address($urandom);
    end
  endtask

  // new lines fill the cache and then evict, mixed with reuse of recent and of long unused lines
  task automatic test_eviction_mix();
    int pick;
    for (int n = 0; n < 75; n++) begin
      pick = $urandom_range(0, 19);
      if (pick < 10) send_address($urandom);
      else if (pick < 14) send_address(reuse_line(addr_history.size() - 32,
                                                  addr_history.size() - 1));
      else send_address(reuse_line(0, 99));
    end
  endtask

  initial begin
    rst          = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.data  = '0;
    mismatches   = 0;
    burst_left   = 0;
    cycle_count  = 0;
    hits_seen    = '0;
    accesses_seen = '0;
    for (int i = 0; i < NUM_LINES; i++) begin
      line_tag[i]   = '0;
      line_valid[i] = 1'b0;
      line_age[i]   = '0;
    end
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_cold_fill();
    test_tag_patterns();
    test_hit_refresh();
    test_random_fill();
    test_eviction_mix();

    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (expected_rsp.size() != 0) @(posedge clk);
    repeat (LOOKUP_LAT) @(posedge clk);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
